[hw/rtl/ias_pkg.sv]
package ias_pkg;

   // Widths fixed by the request and response fields.
   localparam int TIME_WIDTH = 16;
   localparam int GAP_WIDTH = 8;
   localparam int SEL_COUNT_WIDTH = 7;

   // Default store depth, handed to the top level parameter.
   localparam int MAX_INTERVALS_DEFAULT = 16;

   // Configuration register map.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_TURNAROUND_GAP = 1'b0;
   localparam logic [GAP_WIDTH-1:0] GAP_RESET = 8'd1;

   // One request: an interval to load.
   typedef struct packed {
      logic [TIME_WIDTH-1:0] start_time;
      logic [TIME_WIDTH-1:0] end_time;
      logic                  is_last;
   } req_type;

   // One response: a selected interval.
   typedef struct packed {
      logic [TIME_WIDTH-1:0]      sel_start;
      logic [TIME_WIDTH-1:0]      sel_end;
      logic [SEL_COUNT_WIDTH-1:0] sel_count;
      logic                       overflow;
      logic                       last_result;
   } rsp_type;

   // One stored interval, as held in the interval memory.
   typedef struct packed {
      logic [TIME_WIDTH-1:0] start_time;
      logic [TIME_WIDTH-1:0] end_time;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

endpackage

[hw/rtl/ias_ram.sv]
module ias_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ias_alu.sv]
module ias_alu (
   input  logic [ias_pkg::TIME_WIDTH-1:0] op_a,
   input  logic [ias_pkg::TIME_WIDTH-1:0] op_b,
   input  logic [ias_pkg::GAP_WIDTH-1:0]  op_add,
   output logic                           a_ge_sum
);
   import ias_pkg::*;

   logic [TIME_WIDTH:0] sum;

   // The sum carries one extra bit so that a large gap never wraps.
   assign sum = {1'b0, op_b} + (TIME_WIDTH + 1)'(op_add);
   assign a_ge_sum = ({1'b0, op_a} >= sum);

endmodule

[hw/rtl/interval_activity_selection.sv]
// A request that is not last is inserted by walking down the store and moving each stored
// interval with a later end up a place; a dropped request is only marked, as overflow.
// A last request then runs selection over the stored intervals; an output stall can hold it.
// Requests stall until an insertion pass is done; one stored interval per cycle goes through
// the memory and the shared compare unit while no output stall holds the selection.
// Reset clears the counters, flags and output valid, sets the gap to 1 and keeps the memory.
module interval_activity_selection #(
   parameter int MAX_INTERVALS = ias_pkg::MAX_INTERVALS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ias_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ias_pkg::rsp_type                    rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ias_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [ias_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [ias_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import ias_pkg::*;

   localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_INTERVALS);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_INS_CMP   = 3'd1;
   localparam logic [2:0] ST_INS_NEW   = 3'd2;
   localparam logic [2:0] ST_SEL_START = 3'd3;
   localparam logic [2:0] ST_SEL_CMP   = 3'd4;
   localparam logic [2:0] ST_SEL_FLUSH = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              count_ff, count_in;
   entry_type                  new_ff, new_in;
   logic                       last_ff, last_in;
   logic                       dropped_ff, dropped_in;
   logic [TIME_WIDTH-1:0]      last_end_ff, last_end_in;
   logic                       any_sel_ff, any_sel_in;
   logic [SEL_COUNT_WIDTH-1:0] sel_cnt_ff, sel_cnt_in;
   logic                       pend_valid_ff, pend_valid_in;
   entry_type                  pend_ff, pend_in;
   logic [SEL_COUNT_WIDTH-1:0] pend_cnt_ff, pend_cnt_in;
   logic [GAP_WIDTH-1:0]       gap_ff, gap_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic                       req_accept;
   logic                       out_free;
   logic                       take;
   logic                       at_last_idx;
   logic                       csr_write;

   logic                       wr_en;
   logic [IW-1:0]              wr_addr;
   entry_type                  wr_data;
   logic [IW-1:0]              rd_addr;
   entry_type                  rd_entry;
   logic [ENTRY_WIDTH-1:0]     rd_raw;

   logic [TIME_WIDTH-1:0]      alu_a;
   logic [TIME_WIDTH-1:0]      alu_b;
   logic [GAP_WIDTH-1:0]       alu_add;
   logic                       alu_ge;

   // Interval memory, kept ordered by end time.
   ias_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (MAX_INTERVALS),
      .ADDR_WIDTH (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);

   // Shared compare unit: the insertion test during load, the gap test during selection.
   always_comb begin
      if (state_ff == ST_SEL_CMP) begin
         alu_a   = rd_entry.start_time;
         alu_b   = last_end_ff;
         alu_add = gap_ff;
      end else begin
         alu_a   = new_ff.end_time;
         alu_b   = rd_entry.end_time;
         alu_add = '0;
      end
   end

   ias_alu u_alu (
      .op_a     (alu_a),
      .op_b     (alu_b),
      .op_add   (alu_add),
      .a_ge_sum (alu_ge)
   );

   // Configuration port: one register, always ready.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_TURNAROUND_GAP) ?
                       CSR_DATA_WIDTH'(gap_ff) : '0;

   always_comb begin
      gap_in = gap_ff;
      if (csr_write && (csr_paddr[2] == REG_TURNAROUND_GAP)) begin
         gap_in = csr_pwdata[GAP_WIDTH-1:0];
      end
   end

   // Handshake helpers.
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign take        = !any_sel_ff || alu_ge;
   assign at_last_idx = ((CW'(idx_ff) + CW'(1)) == count_ff);

   // Sequencer for insertion and selection.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      new_in        = new_ff;
      last_in       = last_ff;
      dropped_in    = dropped_ff;
      last_end_in   = last_end_ff;
      any_sel_in    = any_sel_ff;
      sel_cnt_in    = sel_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      pend_cnt_in   = pend_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff + IW'(1);
      wr_data       = new_ff;
      rd_addr       = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               new_in.start_time = req_data.start_time;
               new_in.end_time   = req_data.end_time;
               last_in           = req_data.is_last;
               if (count_ff == COUNT_FULL) begin
                  // Store full: drop, but a last request still closes the set.
                  dropped_in = 1'b1;
                  if (req_data.is_last) begin
                     state_in = ST_SEL_START;
                  end
               end else if (count_ff == '0) begin
                  idx_in   = '0;
                  state_in = ST_INS_NEW;
               end else begin
                  idx_in   = IW'(count_ff - CW'(1));
                  rd_addr  = IW'(count_ff - CW'(1));
                  state_in = ST_INS_CMP;
               end
            end
         end

         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (alu_ge) begin
               // Stored end is not above the new end: the new interval goes just after it.
               wr_data  = new_ff;
               count_in = count_ff + CW'(1);
               state_in = last_ff ? ST_SEL_START : ST_IDLE;
            end else begin
               // Move the stored interval up one place and look one lower.
               wr_data = rd_entry;
               if (idx_ff == '0) begin
                  state_in = ST_INS_NEW;
               end else begin
                  idx_in  = idx_ff - IW'(1);
                  rd_addr = idx_ff - IW'(1);
               end
            end
         end

         ST_INS_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = new_ff;
            count_in = count_ff + CW'(1);
            state_in = last_ff ? ST_SEL_START : ST_IDLE;
         end

         ST_SEL_START: begin
            idx_in  = '0;
            rd_addr = '0;
            if (count_ff == '0) begin
               state_in = ST_SEL_FLUSH;
            end else begin
               state_in = ST_SEL_CMP;
            end
         end

         ST_SEL_CMP: begin
            if (take && pend_valid_ff && !out_free) begin
               // Hold the current interval until the previous selection can leave.
               rd_addr = idx_ff;
            end else begin
               if (take) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in            = 1'b1;
                     rsp_data_in.sel_start   = pend_ff.start_time;
                     rsp_data_in.sel_end     = pend_ff.end_time;
                     rsp_data_in.sel_count   = pend_cnt_ff;
                     rsp_data_in.overflow    = dropped_ff;
                     rsp_data_in.last_result = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = rd_entry;
                  pend_cnt_in   = sel_cnt_ff + SEL_COUNT_WIDTH'(1);
                  sel_cnt_in    = sel_cnt_ff + SEL_COUNT_WIDTH'(1);
                  last_end_in   = rd_entry.end_time;
                  any_sel_in    = 1'b1;
               end
               if (at_last_idx) begin
                  state_in = ST_SEL_FLUSH;
               end else begin
                  idx_in  = idx_ff + IW'(1);
                  rd_addr = idx_ff + IW'(1);
               end
            end
         end

         ST_SEL_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               // The held selection is the final one of the set.
               if (pend_valid_ff) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.sel_start   = pend_ff.start_time;
                  rsp_data_in.sel_end     = pend_ff.end_time;
                  rsp_data_in.sel_count   = pend_cnt_ff;
                  rsp_data_in.overflow    = dropped_ff;
                  rsp_data_in.last_result = 1'b1;
               end
               count_in      = '0;
               dropped_in    = 1'b0;
               last_end_in   = '0;
               any_sel_in    = 1'b0;
               sel_cnt_in    = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         last_end_ff   <= '0;
         any_sel_ff    <= 1'b0;
         sel_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         gap_ff        <= GAP_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         last_end_ff   <= last_end_in;
         any_sel_ff    <= any_sel_in;
         sel_cnt_ff    <= sel_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         gap_ff        <= gap_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      new_ff      <= new_in;
      last_ff     <= last_in;
      pend_ff     <= pend_in;
      pend_cnt_ff <= pend_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
